FILE: hdl/ipv4cs_pkg.sv
package ipv4cs_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65535;
    localparam int MIN_HEADER_BYTES     = 20;
    localparam int CALC_W               = 17;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_BAD   = 2'd1,
        STATUS_PROTO = 2'd2
    } status_t;

    // end-around carry fold of a sum of up to four 16-bit words
    function automatic logic [15:0] fold18(input logic [17:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
        return s2[15:0];
    endfunction

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        return fold18({2'b00, a} + {2'b00, b});
    endfunction

endpackage

FILE: hdl/ipv4_tcp_udp_checksum_generator.sv
// The beat carrying last_byte passes the input register, then the result register, to out_valid.
// Throughput: one byte beat per cycle, unless a last beat waits on a stalled result;
// the next packet may follow directly. The whole checksum update for one byte is done
// between the single input register and the result register.
// rst_n clears the byte count, all running sums, the header fields and both valid flags.
module ipv4_tcp_udp_checksum_generator #(
    parameter int MAX_PACKET_BYTES = ipv4cs_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pkt_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] ip_header_sum,
    output logic [15:0] transport_sum,
    output logic [1:0]  status
);
    import ipv4cs_pkg::*;

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

    // input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // packet state
    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic [5:0]       header_bytes_reg;
    logic [5:0]       header_bytes_next;
    logic [7:0]       protocol_reg;
    logic [7:0]       protocol_next;
    logic [15:0]      header_accum_reg;
    logic [15:0]      header_accum_next;
    logic [15:0]      transport_accum_reg;
    logic [15:0]      transport_accum_next;
    logic [7:0]       pending_high_reg;
    logic [7:0]       pending_high_next;
    logic             overflow_reg;
    logic             overflow_next;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] ip_sum_reg;
    logic [15:0] tr_sum_reg;
    logic [1:0]  status_reg;

    logic              accept_in;
    logic              advance;
    logic              drop;
    logic [CALC_W-1:0] pos;
    logic [CALC_W-1:0] hb;
    logic [CALC_W-1:0] toff;
    logic [CALC_W-1:0] n;
    logic              tr_field;
    logic              zero_byte;
    logic [7:0]        v;
    logic              even;
    logic [15:0]       word;
    logic              add_en;
    logic              in_hdr;
    logic              in_pseudo;
    logic [15:0]       hdr_word;
    logic [15:0]       tr_word;
    logic [15:0]       hdr_sum;
    logic [15:0]       tr_sum_upd;
    logic              ovf;
    logic              bad;
    logic              is_l4;
    logic [15:0]       l4_len;
    logic [17:0]       tr_total;
    logic [15:0]       ip_res;
    logic [15:0]       tr_res;
    status_t           status_res;

    assign accept_in = in_valid && in_ready;
    assign advance   = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    always_comb
    begin
        pos  = CALC_W'(byte_count_reg);
        hb   = CALC_W'(header_bytes_reg);
        drop = byte_count_reg >= CNT_W'(MAX_PACKET_BYTES);
        toff = pos - hb;

        tr_field = 1'b0;
        if (pos >= hb)
        begin
            if (protocol_reg == PROTO_TCP)
                tr_field = (toff == CALC_W'(16)) || (toff == CALC_W'(17));
            else if (protocol_reg == PROTO_UDP)
                tr_field = (toff == CALC_W'(6)) || (toff == CALC_W'(7));
        end

        // header checksum field and transport checksum field count as zero
        zero_byte = (pos == CALC_W'(10)) || (pos == CALC_W'(11)) || tr_field;
        v         = zero_byte ? 8'h00 : byte_reg;
        even      = !pos[0];
        word      = even ? {v, 8'h00} : {pending_high_reg, v};
        add_en    = !drop && (!even || last_reg);
        in_hdr    = pos < hb;
        in_pseudo = (pos >= CALC_W'(12)) && (pos < CALC_W'(20));
        hdr_word  = (add_en && in_hdr) ? word : 16'h0000;
        tr_word   = (add_en && (!in_hdr || in_pseudo)) ? word : 16'h0000;

        hdr_sum    = ones_add(header_accum_reg, hdr_word);
        tr_sum_upd = ones_add(transport_accum_reg, tr_word);

        n   = drop ? pos : pos + CALC_W'(1);
        ovf = overflow_reg || drop;
        bad = ovf || (n < CALC_W'(MIN_HEADER_BYTES)) || (hb < CALC_W'(MIN_HEADER_BYTES))
              || (n < hb);
        is_l4  = (protocol_reg == PROTO_TCP) || (protocol_reg == PROTO_UDP);
        l4_len = 16'(n - hb);

        // pseudo-header protocol and length go in with the last word in one fold
        tr_total = {2'b00, transport_accum_reg} + {2'b00, tr_word}
                   + {10'd0, protocol_reg} + {2'b00, l4_len};

        if (bad)
        begin
            ip_res     = 16'h0000;
            tr_res     = 16'h0000;
            status_res = STATUS_BAD;
        end
        else if (is_l4)
        begin
            ip_res     = ~hdr_sum;
            tr_res     = ~fold18(tr_total);
            status_res = STATUS_OK;
        end
        else
        begin
            ip_res     = ~hdr_sum;
            tr_res     = 16'h0000;
            status_res = STATUS_PROTO;
        end
    end

    always_comb
    begin
        byte_count_next      = byte_count_reg;
        header_bytes_next    = header_bytes_reg;
        protocol_next        = protocol_reg;
        header_accum_next    = header_accum_reg;
        transport_accum_next = transport_accum_reg;
        pending_high_next    = pending_high_reg;
        overflow_next        = overflow_reg;
        if (advance)
        begin
            if (last_reg)
            begin
                byte_count_next      = '0;
                header_bytes_next    = '0;
                protocol_next        = '0;
                header_accum_next    = '0;
                transport_accum_next = '0;
                pending_high_next    = '0;
                overflow_next        = 1'b0;
            end
            else
            begin
                overflow_next        = ovf;
                header_accum_next    = hdr_sum;
                transport_accum_next = tr_sum_upd;
                if (!drop)
                begin
                    byte_count_next = CNT_W'(n);
                    if (pos == CALC_W'(0))
                        header_bytes_next = {byte_reg[3:0], 2'b00};
                    if (pos == CALC_W'(9))
                        protocol_next = byte_reg;
                    if (even)
                        pending_high_next = v;
                end
            end
        end
    end

    assign in_valid_next  = accept_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = (advance && last_reg) ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            byte_count_reg      <= '0;
            header_bytes_reg    <= '0;
            protocol_reg        <= '0;
            header_accum_reg    <= '0;
            transport_accum_reg <= '0;
            pending_high_reg    <= '0;
            overflow_reg        <= 1'b0;
        end
        else
        begin
            in_valid_reg        <= in_valid_next;
            out_valid_reg       <= out_valid_next;
            byte_count_reg      <= byte_count_next;
            header_bytes_reg    <= header_bytes_next;
            protocol_reg        <= protocol_next;
            header_accum_reg    <= header_accum_next;
            transport_accum_reg <= transport_accum_next;
            pending_high_reg    <= pending_high_next;
            overflow_reg        <= overflow_next;
        end
    end

    // payload registers: hold the beat and the result
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            byte_reg <= pkt_byte;
            last_reg <= last_byte;
        end
        if (advance && last_reg)
        begin
            ip_sum_reg <= ip_res;
            tr_sum_reg <= tr_res;
            status_reg <= status_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ip_header_sum = ip_sum_reg;
    assign transport_sum = tr_sum_reg;
    assign status        = status_reg;

endmodule

FILE: hdl/ipv4cs_checker.sv
module ipv4cs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] ip_header_sum,
    input logic [15:0] transport_sum,
    input logic [1:0]  status
);
    import ipv4cs_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ip_header_sum)
            && $stable(transport_sum) && $stable(status))
    else $error("result changed while stalled");

    // a fresh result follows an accepted last_byte beat through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
    else $error("result without a last beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> transport_sum == 16'h0000)
    else $error("transport sum nonzero on a flagged packet");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_BAD |-> ip_header_sum == 16'h0000)
    else $error("header sum nonzero on a malformed packet");

endmodule

bind ipv4_tcp_udp_checksum_generator ipv4cs_checker u_ipv4cs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ip_header_sum (ip_header_sum),
    .transport_sum (transport_sum),
    .status        (status)
);

FILE: test/ipv4_tcp_udp_checksum_generator_tb.sv
`timescale 1ns / 1ps

module ipv4_tcp_udp_checksum_generator_tb;

    import ipv4cs_pkg::*;

    localparam int MAX_BYTES = MAX_PACKET_BYTES_DEF;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct packed {
        logic [15:0] ip;
        logic [15:0] seg;
        status_t     code;
    } sums_t;

    // Scoreboard: tracks the running checksums of the packet in flight and
    // holds the sums owed by the block, oldest first.
    class sum_scoreboard;
        sums_t       owed_sums[$];
        int          faults;
        logic [16:0] seen;
        logic [5:0]  hdr_len;
        logic [7:0]  proto;
        logic [15:0] hdr_acc;
        logic [15:0] seg_acc;
        logic [7:0]  hi_byte;
        bit          too_long;

        function new();
            faults = 0;
            clear();
        endfunction

        function void clear();
            seen     = '0;
            hdr_len  = '0;
            proto    = '0;
            hdr_acc  = '0;
            seg_acc  = '0;
            hi_byte  = '0;
            too_long = 1'b0;
        endfunction

        function int pending();
            return owed_sums.size();
        endfunction

        static function logic [15:0] wrap_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        endfunction

        function bit in_csum_field(logic [16:0] pos);
            logic [16:0] off;
            if (pos < hdr_len)
                return 1'b0;
            off = pos - hdr_len;
            if (proto == PROTO_TCP)
                return off == 17'd16 || off == 17'd17;
            if (proto == PROTO_UDP)
                return off == 17'd6 || off == 17'd7;
            return 1'b0;
        endfunction

        function void add_word(logic [16:0] pos, logic [15:0] w);
            if (pos < hdr_len)
            begin
                hdr_acc = wrap_add(hdr_acc, w);
                // addresses also feed the pseudo-header
                if (pos >= 17'd12 && pos < 17'd20)
                    seg_acc = wrap_add(seg_acc, w);
            end
            else
                seg_acc = wrap_add(seg_acc, w);
        endfunction

        function void note_byte(logic [7:0] b, logic lst);
            logic [16:0] pos;
            logic [7:0]  v;
            logic [16:0] seg_len;
            logic [15:0] acc;
            sums_t       e;
            if (seen >= MAX_BYTES)
                too_long = 1'b1;
            else
            begin
                pos = seen;
                v   = b;
                if (pos == 17'd0)
                    hdr_len = {b[3:0], 2'b00};
                if (pos == 17'd9)
                    proto = b;
                if (pos == 17'd10 || pos == 17'd11 || in_csum_field(pos))
                    v = 8'h00;
                if (!pos[0])
                begin
                    hi_byte = v;
                    // pad an odd tail with a zero low byte
                    if (lst)
                        add_word(pos, {v, 8'h00});
                end
                else
                    add_word(pos, {hi_byte, v});
                seen = pos + 17'd1;
            end
            if (!lst)
                return;
            if (too_long || seen < MIN_HEADER_BYTES || hdr_len < MIN_HEADER_BYTES ||
                seen < hdr_len)
                e = '{16'h0000, 16'h0000, STATUS_BAD};
            else if (proto == PROTO_TCP || proto == PROTO_UDP)
            begin
                seg_len = seen - hdr_len;
                acc = wrap_add(seg_acc, {8'h00, proto});
                acc = wrap_add(acc, seg_len[15:0]);
                e = '{~hdr_acc, ~acc, STATUS_OK};
            end
            else
                e = '{~hdr_acc, 16'h0000, STATUS_PROTO};
            owed_sums.push_back(e);
            clear();
        endfunction

        function void check_sums(logic [15:0] got_ip, logic [15:0] got_seg, logic [1:0] got_st);
            sums_t e;
            if (owed_sums.size() == 0)
            begin
                $display("%0t ns: unexpected result ip %h transport %h status %0d",
                         $time, got_ip, got_seg, got_st);
                faults++;
                return;
            end
            e = owed_sums.pop_front();
            if (got_ip !== e.ip)
            begin
                $display("%0t ns: ip_header_sum expected %h actual %h", $time, e.ip, got_ip);
                faults++;
            end
            if (got_seg !== e.seg)
            begin
                $display("%0t ns: transport_sum expected %h actual %h", $time, e.seg, got_seg);
                faults++;
            end
            if (got_st !== e.code)
            begin
                $display("%0t ns: status expected %0d actual %0d", $time, e.code, got_st);
                faults++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pkt_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] ip_header_sum;
    logic [15:0] transport_sum;
    logic [1:0]  status;

    sum_scoreboard sums = new();
    int            beats_sent = 0;

    always #10 clk = ~clk;

    ipv4_tcp_udp_checksum_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pkt_byte     (pkt_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ip_header_sum(ip_header_sum),
        .transport_sum(transport_sum),
        .status       (status)
    );

    task automatic send_beat(input logic [7:0] b, input logic lst, input bit steady);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pkt_byte  <= b;
        last_byte <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sums.note_byte(b, lst);
        beats_sent++;
    endtask

    task automatic send_frame(input logic [7:0] first, input logic [7:0] proto, input int len,
                              input fill_t fill, input bit steady);
        logic [7:0] frame[$];
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: frame.push_back(8'h00);
                FILL_ONES: frame.push_back(8'hff);
                default:   frame.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        frame[0] = first;
        if (len > 9)
            frame[9] = proto;
        for (int i = 0; i < len; i++)
            send_beat(frame[i], i == len - 1, steady);
    endtask

    // hold the sender off until every owed result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sums.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sums.check_sums(ip_header_sum, transport_sum, status);
        end
    end

    initial
    begin
        logic [7:0] first;
        logic [7:0] proto;
        logic [3:0] ihl;
        int         len;
        int         kind;
        int         rnd_beats;
        int         rnd_frames;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        pkt_byte  <= 8'h00;
        last_byte <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_frame(8'h45, PROTO_TCP, 40, FILL_ZERO, 1'b0);
        send_frame(8'h45, PROTO_UDP, 28, FILL_ONES, 1'b0);
        send_frame(8'h45, PROTO_TCP, 41, FILL_RANDOM, 1'b0);
        send_frame(8'h45, PROTO_UDP, 33, FILL_RANDOM, 1'b1);
        send_frame(8'h45, PROTO_TCP, 20, FILL_RANDOM, 1'b0);
        // transport ends inside the checksum field
        send_frame(8'h45, PROTO_TCP, 37, FILL_RANDOM, 1'b0);
        send_frame(8'h45, PROTO_UDP, 27, FILL_RANDOM, 1'b0);
        send_frame(8'h45, 8'd1, 30, FILL_RANDOM, 1'b0);
        send_frame(8'hff, 8'hff, 61, FILL_ONES, 1'b1);
        send_frame(8'h4f, PROTO_TCP, 80, FILL_RANDOM, 1'b0);
        send_frame(8'h4f, PROTO_UDP, 40, FILL_RANDOM, 1'b0);
        send_frame(8'h44, PROTO_TCP, 40, FILL_RANDOM, 1'b0);
        send_frame(8'h40, PROTO_UDP, 30, FILL_ZERO, 1'b0);
        send_frame(8'h45, PROTO_TCP, 1, FILL_RANDOM, 1'b0);
        send_frame(8'h45, PROTO_TCP, 19, FILL_RANDOM, 1'b0);
        send_frame(8'h45, PROTO_UDP, 28, FILL_RANDOM, 1'b1);
        drain();

        rnd_beats  = beats_sent;
        rnd_frames = 0;
        while (beats_sent - rnd_beats < 750 || rnd_frames < 40)
        begin
            kind  = $urandom_range(0, 99);
            ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            first = {4'h4, ihl};
            if (kind < 75)
            begin
                proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
                len   = int'(ihl) * 4 + $urandom_range(0, 40);
            end
            else if (kind < 85)
            begin
                proto = 8'($urandom_range(0, 255));
                len   = int'(ihl) * 4 + $urandom_range(0, 30);
            end
            else
            begin
                first = 8'($urandom_range(0, 255));
                proto = 8'($urandom_range(0, 255));
                len   = $urandom_range(1, 70);
            end
            send_frame(first, proto, len, FILL_RANDOM, $urandom_range(0, 4) == 0);
            rnd_frames++;
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        in_valid <= 1'b0;

        for (int i = 0; i < 2000 && sums.pending() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sums.pending() != 0)
        begin
            $display("%0t ns: %0d results never arrived", $time, sums.pending());
            sums.faults++;
        end
        if (sums.faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/ipv4cs_pkg.sv
hdl/ipv4_tcp_udp_checksum_generator.sv
hdl/ipv4cs_checker.sv
test/ipv4_tcp_udp_checksum_generator_tb.sv
